@@ rtl/core/psb_pkg.sv @@
// Package for the parameter smoothing bank: word types, field widths,
// register codes, fixed-point constants and the sequencer state type.
// Used by psb_div, parameter_smoothing_bank_unit and the testbench; depends on nothing.
package psb_pkg;

    localparam int DATA_W     = 24;
    localparam int CH_FIELD_W = 4;
    localparam int TIME_W     = 24;
    localparam int DEN_W      = TIME_W + 1;
    localparam int PROD_W     = 49;
    localparam int QUOT_W     = 24;

    localparam int NUM_CHANNELS_DEF = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TIME_W-1:0] BLEND_TC_RESET = 24'd300000;
    localparam logic [TIME_W-1:0] PARAM_TC_RESET = 24'd600000;
    localparam logic [TIME_W-1:0] DT_MIN_US      = 24'd1000;

    localparam logic signed [DATA_W-1:0] SNAP_LO_Q    = 24'sd13107;
    localparam logic signed [DATA_W-1:0] SNAP_HI_Q    = 24'sd52429;
    localparam logic signed [DATA_W:0]   SCENE_BIAS_Q = 25'sd6554;
    localparam logic signed [DATA_W:0]   SCENE_ROUND  = 25'sd65535;
    localparam logic [QUOT_W-1:0]        QUOT_MAX     = 24'h800000;

    localparam int CH_BLEND   = 0;
    localparam int CH_SCENE_A = 1;
    localparam int CH_SCENE_B = 2;
    localparam int CH_CLIP    = 9;

    typedef enum logic {
        REG_BLEND_TC = 1'b0,
        REG_PARAM_TC = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_TICK  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [CH_FIELD_W-1:0]      channel_index;
        logic signed [DATA_W-1:0]   target_value;
        logic [TIME_W-1:0]          elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]      out_channel;
        logic signed [DATA_W-1:0]   out_value;
        logic                       last_of_tick;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL_T,
        S_MUL_O,
        S_SUM,
        S_ABS,
        S_DIV,
        S_FIN
    } t_state;

endpackage

@@ rtl/core/psb_div.sv @@
// Restoring divider for the smoothing bank: one quotient bit per cycle.
// Depends on psb_pkg for widths and the status struct.
module psb_div import psb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_dividend,
    input  logic [DEN_W-1:0]    i_divisor,
    output t_div_status         o_status,
    output logic [QUOT_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [QUOT_W-1:0]  r_low;
    logic [DEN_W-1:0]   r_den;

    logic [DEN_W:0]     w_shift;
    logic [DEN_W+1:0]   w_diff;
    logic               w_fit;

    assign w_shift = {r_rem, r_low[QUOT_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_fit   = !w_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(QUOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:QUOT_W];
            r_low <= i_dividend[QUOT_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], w_fit};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_low;

endmodule

@@ rtl/core/parameter_smoothing_bank_unit.sv @@
// Top level of the parameter smoothing bank: sequencer, target and smoothed
// memories, shared multiplier and output register. Depends on psb_pkg and psb_div.
//
// A write word stores one channel's target and is taken while no tick runs. A tick
// word walks all NUM_CHANNELS channels in order, reading both memories, forming
// target*dt + old*k on one shared 24x25 multiplier in states S_MUL_T and S_MUL_O,
// dividing by dt + k in a bit-serial divider of 24 steps and emitting one result
// word per channel; the new value is written back for all but the scene channels.
// The input stays stalled for the whole tick, and output stalls lengthen the tick.
// Configuration registers are read and written through the APB port at byte
// addresses 0 and 4; pready is always high.
module parameter_smoothing_bank_unit import psb_pkg::*; #(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_in_word                i_in_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out_word               o_out_word,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int CH_W = $clog2(NUM_CHANNELS);

    t_state                     r_state;
    t_state                     n_state;

    logic [TIME_W-1:0]          r_blend_tc;
    logic [TIME_W-1:0]          r_param_tc;

    logic signed [DATA_W-1:0]   r_tgt_mem [NUM_CHANNELS];
    logic signed [DATA_W-1:0]   r_smo_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]    r_tgt_vld;
    logic [NUM_CHANNELS-1:0]    r_smo_vld;
    logic signed [DATA_W-1:0]   r_tgt_rd;
    logic signed [DATA_W-1:0]   r_smo_rd;
    logic                       r_tgt_rv;
    logic                       r_smo_rv;

    logic [CH_W-1:0]            r_ch;
    logic [TIME_W-1:0]          r_dt;
    logic [TIME_W-1:0]          r_k;
    logic [DEN_W-1:0]           r_den;
    logic signed [DATA_W-1:0]   r_t;
    logic signed [DATA_W-1:0]   r_o;
    logic signed [PROD_W-1:0]   r_p1;
    logic signed [PROD_W-1:0]   r_p2;
    logic signed [PROD_W-1:0]   r_num;
    logic                       r_neg;

    logic                       r_out_vld;
    t_out_word                  r_out_word;

    logic                       w_in_acc;
    logic                       w_cfg_wr;
    logic                       w_tgt_wr;
    logic [CH_W-1:0]            w_tgt_addr;
    logic [TIME_W-1:0]          w_dt;
    logic signed [DATA_W-1:0]   w_rd_t;
    logic signed [DATA_W-1:0]   w_rd_o;
    logic signed [DATA_W-1:0]   w_mul_a;
    logic signed [DEN_W-1:0]    w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic [DATA_W-1:0]          w_half;
    logic [PROD_W-1:0]          w_dvd;
    logic                       w_div_start;
    t_div_status                w_div_stat;
    logic [QUOT_W-1:0]          w_quot;

    logic                       w_is_blend;
    logic                       w_scene;
    logic                       w_is_clip;
    logic                       w_last;
    logic                       w_snap;
    logic signed [DATA_W-1:0]   w_blend;
    logic signed [DATA_W-1:0]   w_v;
    logic signed [DATA_W:0]     w_sc;
    logic signed [DATA_W:0]     w_sc_adj;
    logic signed [DATA_W-1:0]   w_scene_num;
    logic signed [DATA_W-1:0]   w_shown;
    logic                       w_out_load;
    logic                       w_smo_wr;

    assign w_in_acc   = i_valid && !o_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    assign w_tgt_wr   = w_in_acc && (i_in_word.kind == KIND_WRITE)
                        && (32'(i_in_word.channel_index) < NUM_CHANNELS);
    assign w_tgt_addr = CH_W'(i_in_word.channel_index);
    assign w_dt       = (i_in_word.elapsed_us < DT_MIN_US) ? DT_MIN_US
                                                           : i_in_word.elapsed_us;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_tc <= BLEND_TC_RESET;
            r_param_tc <= PARAM_TC_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_BLEND_TC: r_blend_tc <= pwdata[TIME_W-1:0];
                REG_PARAM_TC: r_param_tc <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_BLEND_TC: prdata = APB_DATA_W'(r_blend_tc);
            REG_PARAM_TC: prdata = APB_DATA_W'(r_param_tc);
            default:      prdata = '0;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        w_smo_wr    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_word.kind == KIND_TICK)) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_MUL_T;
            S_MUL_T: n_state = S_MUL_O;
            S_MUL_O: n_state = S_SUM;
            S_SUM:   n_state = S_ABS;
            S_ABS: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_vld || !i_stall) begin
                    w_out_load = 1'b1;
                    w_smo_wr   = !w_scene;
                    n_state    = w_last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (w_in_acc && (i_in_word.kind == KIND_TICK)) begin
            r_ch <= '0;
        end else if (w_out_load && !w_last) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // Memories: one read per channel, written back except on the scene channels.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_tgt_rd <= r_tgt_mem[r_ch];
            r_smo_rd <= r_smo_mem[r_ch];
            r_tgt_rv <= r_tgt_vld[r_ch];
            r_smo_rv <= r_smo_vld[r_ch];
        end
        if (w_tgt_wr) begin
            r_tgt_mem[w_tgt_addr] <= i_in_word.target_value;
        end
        if (w_smo_wr) begin
            r_smo_mem[r_ch] <= w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_vld <= '0;
            r_smo_vld <= '0;
        end else begin
            if (w_tgt_wr) begin
                r_tgt_vld[w_tgt_addr] <= 1'b1;
            end
            if (w_smo_wr) begin
                r_smo_vld[r_ch] <= 1'b1;
            end
        end
    end

    assign w_rd_t = r_tgt_rv ? r_tgt_rd : '0;
    assign w_rd_o = r_smo_rv ? r_smo_rd : '0;

    // Shared multiplier: target * dt first, then old * k.
    assign w_mul_a = (r_state == S_MUL_T) ? w_rd_t : r_o;
    assign w_mul_b = (r_state == S_MUL_T) ? $signed({1'b0, r_dt}) : $signed({1'b0, r_k});
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_half = r_den[DEN_W-1:1];
    assign w_dvd  = r_num[PROD_W-1] ? (~r_num) + PROD_W'(w_half) + PROD_W'(1)
                                     : r_num + PROD_W'(w_half);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_word.kind == KIND_TICK)) begin
            r_dt <= w_dt;
        end
        unique case (r_state)
            S_MUL_T: begin
                r_t   <= w_rd_t;
                r_o   <= w_rd_o;
                r_p1  <= w_prod;
                r_k   <= w_is_blend ? r_blend_tc : r_param_tc;
                r_den <= {1'b0, r_dt} + (w_is_blend ? {1'b0, r_blend_tc}
                                                    : {1'b0, r_param_tc});
            end
            S_MUL_O: r_p2  <= w_prod;
            S_SUM:   r_num <= r_p1 + r_p2;
            S_ABS:   r_neg <= r_num[PROD_W-1];
            default: ;
        endcase
    end

    psb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (r_den),
        .o_status   (w_div_stat),
        .o_quotient (w_quot)
    );

    // Final value, special channels and result word.
    assign w_is_blend = (r_ch == CH_W'(CH_BLEND));
    assign w_scene    = (r_ch == CH_W'(CH_SCENE_A)) || (r_ch == CH_W'(CH_SCENE_B));
    assign w_is_clip  = (r_ch == CH_W'(CH_CLIP));
    assign w_last     = (r_ch == CH_W'(NUM_CHANNELS - 1));

    assign w_snap  = ((r_t <= SNAP_LO_Q) && (r_o >= SNAP_HI_Q))
                     || ((r_t >= SNAP_HI_Q) && (r_o <= SNAP_LO_Q));
    assign w_blend = r_neg ? $signed(QUOT_W'(0) - w_quot) : $signed(w_quot);

    always_comb begin
        if (w_is_blend) begin
            w_v = (w_blend < 0) ? '0 : w_blend;
        end else if (w_snap) begin
            w_v = r_t;
        end else begin
            w_v = w_blend;
        end
    end

    assign w_sc        = $signed({r_t[DATA_W-1], r_t}) + SCENE_BIAS_Q;
    assign w_sc_adj    = w_sc[DATA_W] ? w_sc + SCENE_ROUND : w_sc;
    assign w_scene_num = {{(DATA_W-9){w_sc_adj[DATA_W]}}, w_sc_adj[DATA_W:16]};

    always_comb begin
        if (w_scene) begin
            w_shown = w_scene_num;
        end else if (w_is_clip && (w_v <= 0)) begin
            w_shown = '0;
        end else begin
            w_shown = w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word.out_channel  <= r_ch[CH_FIELD_W-1:0];
            r_out_word.out_value    <= w_shown;
            r_out_word.last_of_tick <= w_last;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_out_word = r_out_word;

    a_tick_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.kind == KIND_TICK)) |=> (r_state == S_READ))
        else $error("tick word did not start the channel walk");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div_stat.busy || w_div_stat.done))
        else $error("sequencer waits on an idle divider");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (w_quot <= QUOT_MAX))
        else $error("quotient exceeds the value range");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_word.last_of_tick)
            |-> (o_out_word.out_channel == CH_FIELD_W'(NUM_CHANNELS - 1)))
        else $error("last word of a tick carries the wrong channel");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for parameter_smoothing_bank_unit: directed table, then
// random write and tick words with random idling, checked against a local predictor.
// Depends on psb_pkg and the RTL of the smoothing bank only.
module testbench;
    import psb_pkg::*;

    localparam int Q_ONE          = 65536;
    localparam int NUM_ROWS       = 25;
    localparam int NUM_PHASES     = 4;
    localparam int PHASE_WORDS    = 62;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        t_kind                    kind;
        logic [CH_FIELD_W-1:0]    ch;
        logic signed [DATA_W-1:0] value;
        logic [TIME_W-1:0]        dt;
        logic                     chk;
        logic [CH_FIELD_W-1:0]    chk_ch;
        logic signed [DATA_W-1:0] chk_val;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_in_word;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic signed [DATA_W-1:0] goal_q [NUM_CHANNELS_DEF];
    logic signed [DATA_W-1:0] level_q [NUM_CHANNELS_DEF];
    logic [TIME_W-1:0]        k_blend;
    logic [TIME_W-1:0]        k_param;
    t_out_word                predicted_words [$];

    int faults       = 0;
    int words_sent   = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int calm_words   = 0;
    int quiet_cycles = 0;

    t_row plan [NUM_ROWS] = '{
        '{KIND_TICK,  4'd0,  24'sd0,        24'd0,        1'b1, 4'd0,  24'sd0},
        '{KIND_WRITE, 4'd1,  24'sh7FFFFF,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd1000,     1'b1, 4'd1,  24'sd128},
        '{KIND_WRITE, 4'd2,  24'sh800000,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd999,      1'b1, 4'd2,  -24'sd127},
        '{KIND_WRITE, 4'd1,  24'sd58982,    24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_WRITE, 4'd2,  24'sd58981,    24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd5000,     1'b1, 4'd1,  24'sd1},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd5000,     1'b1, 4'd2,  24'sd0},
        '{KIND_WRITE, 4'd0,  -24'sd65536,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd20000,    1'b1, 4'd0,  24'sd0},
        '{KIND_WRITE, 4'd9,  -24'sd65536,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd20000,    1'b1, 4'd9,  24'sd0},
        '{KIND_WRITE, 4'd5,  24'sd65536,    24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd1000,     1'b1, 4'd5,  24'sd65536},
        '{KIND_WRITE, 4'd5,  24'sd0,        24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd1000,     1'b1, 4'd5,  24'sd0},
        '{KIND_WRITE, 4'd3,  24'sh7FFFFF,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'hFFFFFF,   1'b1, 4'd3,  24'sh7FFFFF},
        '{KIND_WRITE, 4'd4,  24'sd52429,    24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd0,        1'b1, 4'd4,  24'sd52429},
        '{KIND_WRITE, 4'd15, 24'sd13107,    24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_WRITE, 4'd6,  24'sh800000,   24'd0,        1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'hF,  24'shFFFFFF,   24'hFFFFFF,   1'b0, 4'd0,  24'sd0},
        '{KIND_TICK,  4'd0,  24'sd0,        24'd33333,    1'b0, 4'd0,  24'sd0}
    };

    parameter_smoothing_bank_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_target();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 24'sh7FFFFF;
                    1: return 24'sh800000;
                    2: return 24'sd0;
                    default: return -24'sd1;
                endcase
            end
            1: begin
                if ($urandom_range(0, 1) == 1)
                    return DATA_W'(int'(SNAP_LO_Q) + int'($urandom_range(0, 2)) - 1);
                return DATA_W'(int'(SNAP_HI_Q) + int'($urandom_range(0, 2)) - 1);
            end
            2: return DATA_W'((int'($urandom_range(0, 6)) - 3) * Q_ONE - int'(SCENE_BIAS_Q)
                              + int'($urandom_range(0, 2)) - 1);
            5: return DATA_W'($urandom());
            default: return DATA_W'(int'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_elapsed();
        case ($urandom_range(0, 5))
            0: return TIME_W'($urandom_range(0, 1000));
            1, 2: return TIME_W'($urandom_range(1000, 50000));
            3: return TIME_W'($urandom_range(50000, 2000000));
            4: return 24'hFFFFFF;
            default: return TIME_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] ease(input logic signed [DATA_W-1:0] goal,
                                                      input logic signed [DATA_W-1:0] old,
                                                      input logic [TIME_W-1:0] dt,
                                                      input logic [TIME_W-1:0] k);
        longint num;
        longint den;
        longint q;
        num = longint'(goal) * longint'(dt) + longint'(old) * longint'(k);
        den = longint'(dt) + longint'(k);
        if (num >= 0)
            q = (num + den / 2) / den;
        else
            q = -((-num + den / 2) / den);
        return DATA_W'(q);
    endfunction

    task automatic advance_bank(input t_in_word w, input logic chk,
                                input logic [CH_FIELD_W-1:0] chk_ch,
                                input logic signed [DATA_W-1:0] chk_val);
        logic [TIME_W-1:0]        dt;
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] o;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] shown;
        t_out_word                r;
        if (w.kind == KIND_WRITE) begin
            goal_q[w.channel_index] = w.target_value;
        end else begin
            dt = (w.elapsed_us < DT_MIN_US) ? DT_MIN_US : w.elapsed_us;
            for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
                t = goal_q[c];
                o = level_q[c];
                if (c == CH_SCENE_A || c == CH_SCENE_B) begin
                    shown = DATA_W'((int'(t) + int'(SCENE_BIAS_Q)) / Q_ONE);
                end else begin
                    if (c == CH_BLEND) begin
                        v = ease(t, o, dt, k_blend);
                        if (v < 0)
                            v = '0;
                    end else if ((t <= SNAP_LO_Q && o >= SNAP_HI_Q) ||
                                 (t >= SNAP_HI_Q && o <= SNAP_LO_Q)) begin
                        v = t;
                    end else begin
                        v = ease(t, o, dt, k_param);
                    end
                    level_q[c] = v;
                    shown = v;
                    if (c == CH_CLIP && v <= 0)
                        shown = '0;
                end
                r.out_channel  = CH_FIELD_W'(c);
                r.out_value    = (chk && chk_ch == CH_FIELD_W'(c)) ? chk_val : shown;
                r.last_of_tick = (c == NUM_CHANNELS_DEF - 1);
                predicted_words.push_back(r);
            end
        end
    endtask

    task automatic send_word(input t_in_word w, input logic chk,
                             input logic [CH_FIELD_W-1:0] chk_ch,
                             input logic signed [DATA_W-1:0] chk_val);
        int gap;
        i_valid   <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_stall);
        advance_bank(w, chk, chk_ch, chk_val);
        words_sent++;
        if (w.kind == KIND_TICK)
            ticks_sent++;
        if (calm_words > 0) begin
            calm_words--;
            gap = 0;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 15) == 0)
                calm_words = $urandom_range(10, 30);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_write(input int ch, input logic signed [DATA_W-1:0] value);
        t_in_word w;
        w.kind          = KIND_WRITE;
        w.channel_index = CH_FIELD_W'(ch);
        w.target_value  = value;
        w.elapsed_us    = TIME_W'($urandom());
        send_word(w, 1'b0, '0, '0);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] dt);
        t_in_word w;
        w.kind          = KIND_TICK;
        w.channel_index = CH_FIELD_W'($urandom());
        w.target_value  = DATA_W'($urandom());
        w.elapsed_us    = dt;
        send_word(w, 1'b0, '0, '0);
    endtask

    task automatic run_phase(input int n);
        int                       sent;
        int                       ch;
        int                       reps;
        logic signed [DATA_W-1:0] first;
        logic signed [DATA_W-1:0] second;
        logic [63:0]              bits;
        t_in_word                 w;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    ch     = $urandom_range(3, NUM_CHANNELS_DEF - 1);
                    first  = SNAP_HI_Q + DATA_W'($urandom_range(0, Q_ONE));
                    second = SNAP_LO_Q - DATA_W'($urandom_range(0, 2 * Q_ONE));
                    if ($urandom_range(0, 1) == 1) begin
                        first  = second;
                        second = SNAP_HI_Q + DATA_W'($urandom_range(0, Q_ONE));
                    end
                    send_write(ch, first);
                    send_tick(24'hFFFFFF);
                    send_write(ch, second);
                    send_tick(pick_elapsed());
                    sent += 4;
                end
                2: begin
                    bits = {$urandom(), $urandom()};
                    w    = bits[$bits(t_in_word)-1:0];
                    send_word(w, 1'b0, '0, '0);
                    sent += 1;
                end
                default: begin
                    reps = $urandom_range(1, 4);
                    repeat (reps) send_write($urandom_range(0, NUM_CHANNELS_DEF - 1), pick_target());
                    send_tick(pick_elapsed());
                    sent += reps + 1;
                end
            endcase
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (predicted_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic apb_access(input t_reg_idx idx, input logic wr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input t_reg_idx idx, input logic [TIME_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== APB_DATA_W'(want)) begin
            $display("%0t: register %s read expected %0d, got %0d", $time, idx.name(), want, rd);
            faults++;
        end
    endtask

    task automatic set_time_constant(input t_reg_idx idx, input logic [TIME_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(idx, 1'b1, APB_DATA_W'(value), rd);
        if (idx == REG_BLEND_TC)
            k_blend = value;
        else
            k_param = value;
        reg_check(idx, value);
    endtask

    initial begin : stall_gen
        int n;
        i_stall <= 1'b0;
        forever begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 24);
            repeat (n) @(posedge i_clk);
            n = idle_len();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (predicted_words.size() == 0) begin
                $display("%0t: result word for channel %0d with nothing expected",
                         $time, o_out_word.out_channel);
                faults++;
            end else begin
                want = predicted_words.pop_front();
                if (o_out_word.out_channel !== want.out_channel) begin
                    $display("%0t: out_channel expected %0d, got %0d",
                             $time, want.out_channel, o_out_word.out_channel);
                    faults++;
                end
                if (o_out_word.out_value !== want.out_value) begin
                    $display("%0t: channel %0d out_value expected %0d, got %0d", $time,
                             want.out_channel, want.out_value, o_out_word.out_value);
                    faults++;
                end
                if (o_out_word.last_of_tick !== want.last_of_tick) begin
                    $display("%0t: channel %0d last_of_tick expected %0b, got %0b", $time,
                             want.out_channel, want.last_of_tick, o_out_word.last_of_tick);
                    faults++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in_word          w;
        logic [TIME_W-1:0] blend_plan [NUM_PHASES];
        logic [TIME_W-1:0] param_plan [NUM_PHASES];
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_word <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        k_blend = BLEND_TC_RESET;
        k_param = PARAM_TC_RESET;
        for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
            goal_q[c]  = '0;
            level_q[c] = '0;
        end
        blend_plan = '{24'd0, 24'hFFFFFF, 24'd0, 24'd1000};
        param_plan = '{24'hFFFFFF, 24'd0, 24'd0, 24'd300000};
        blend_plan[2] = TIME_W'($urandom());
        param_plan[2] = TIME_W'($urandom());

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_check(REG_BLEND_TC, BLEND_TC_RESET);
        reg_check(REG_PARAM_TC, PARAM_TC_RESET);

        for (int i = 0; i < NUM_ROWS; i++) begin
            w.kind          = plan[i].kind;
            w.channel_index = plan[i].ch;
            w.target_value  = plan[i].value;
            w.elapsed_us    = plan[i].dt;
            send_word(w, plan[i].chk, plan[i].chk_ch, plan[i].chk_val);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_time_constant(REG_BLEND_TC, blend_plan[p]);
            set_time_constant(REG_PARAM_TC, param_plan[p]);
            run_phase(PHASE_WORDS);
        end

        drain();
        $display("Sent %0d input words (%0d ticks) and checked %0d result words.",
                 words_sent, ticks_sent, results_seen);
        $display("Time constants ran at reset values and %0d written settings, zero and full scale among them.",
                 NUM_PHASES);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ parameter_smoothing_bank_unit.f @@
rtl/core/psb_pkg.sv
rtl/core/psb_div.sv
rtl/core/parameter_smoothing_bank_unit.sv
sim/testbench.sv
